@@ hdl/bpit_pkg.sv @@
// Package for the barycentric point-in-triangle test.
// Default widths and the fixed result width; no dependencies.
package bpit_pkg;

  // Default coordinate width (signed Q12.4)
  localparam int COORD_BITS_DEF = 16;
  // Default fraction bits of the weights (Q16.16)
  localparam int WEIGHT_FRAC_DEF = 16;
  // Width of each weight
  localparam int WEIGHT_BITS = 32;

endpackage

@@ hdl/barycentric_point_in_triangle.sv @@
// Top level of the barycentric point-in-triangle test: a fully pipelined datapath.
// Depends on bpit_pkg.
//
// Usage:
//   Input channel: drive point P and corners A, B, C on the in_* ports and pulse start.
//   A beat is taken at each rising edge with start high and busy low. busy is always
//   low, so one test can enter every cycle.
//   Result channel: out_valid is high for exactly one cycle per test, with
//   out_weight_u, out_weight_v (signed, WEIGHT_FRAC_BITS fraction bits, saturated),
//   out_inside_res and out_degenerate. Results leave in the order the tests entered.
//   The pipeline holds 8 arithmetic stages (edge vectors, component products, dot
//   products, two stages per wide product, the determinant and numerators,
//   magnitudes, and the overflow check), then one restoring-divider stage for each
//   of the 31 quotient bits, then the output register.
//   Throughput: one test per cycle.
//   Reset (rst_n low at a clock edge) clears every valid bit, so tests in flight are
//   dropped. The receiver cannot stall, so results are never held back.
module barycentric_point_in_triangle
  import bpit_pkg::*;
#(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_point_x,
  input  logic signed [COORD_BITS-1:0]  in_point_y,
  input  logic signed [COORD_BITS-1:0]  in_point_z,
  input  logic signed [COORD_BITS-1:0]  in_corner_a_x,
  input  logic signed [COORD_BITS-1:0]  in_corner_a_y,
  input  logic signed [COORD_BITS-1:0]  in_corner_a_z,
  input  logic signed [COORD_BITS-1:0]  in_corner_b_x,
  input  logic signed [COORD_BITS-1:0]  in_corner_b_y,
  input  logic signed [COORD_BITS-1:0]  in_corner_b_z,
  input  logic signed [COORD_BITS-1:0]  in_corner_c_x,
  input  logic signed [COORD_BITS-1:0]  in_corner_c_y,
  input  logic signed [COORD_BITS-1:0]  in_corner_c_z,
  output logic                          out_valid,
  output logic signed [WEIGHT_BITS-1:0] out_weight_u,
  output logic signed [WEIGHT_BITS-1:0] out_weight_v,
  output logic                          out_inside_res,
  output logic                          out_degenerate
);

  // Derived widths
  localparam int EW  = COORD_BITS + 1;      // edge component
  localparam int PW  = 2 * EW;              // component product
  localparam int DW  = PW + 2;              // dot product
  localparam int LB  = (DW + 1) / 2;        // low slice of a multiplier operand
  localparam int HB  = DW - LB;             // high slice
  localparam int MW  = 2 * DW;              // full product of two dot products
  localparam int NW  = MW + 1;              // determinant and numerators
  localparam int QB  = WEIGHT_BITS - 1;     // quotient bits below saturation
  localparam int RW  = NW + WEIGHT_BITS;    // divider remainder
  localparam int LAT = 9 + QB;              // accept edge to result edge

  // Every beat is taken
  assign busy = 1'b0;

  // Gather coordinates per axis
  logic signed [COORD_BITS-1:0] pnt [3];
  logic signed [COORD_BITS-1:0] crn_a [3];
  logic signed [COORD_BITS-1:0] crn_b [3];
  logic signed [COORD_BITS-1:0] crn_c [3];

  always_comb begin
    pnt[0]   = in_point_x;    pnt[1]   = in_point_y;    pnt[2]   = in_point_z;
    crn_a[0] = in_corner_a_x; crn_a[1] = in_corner_a_y; crn_a[2] = in_corner_a_z;
    crn_b[0] = in_corner_b_x; crn_b[1] = in_corner_b_y; crn_b[2] = in_corner_b_z;
    crn_c[0] = in_corner_c_x; crn_c[1] = in_corner_c_y; crn_c[2] = in_corner_c_z;
  end

  // Stage 1: edge vectors C-A, B-A, P-A
  logic                 s1_vld_r;
  logic signed [EW-1:0] e0_r [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    for (int k = 0; k < 3; k++) begin
      e0_r[k] <= EW'(crn_c[k]) - EW'(crn_a[k]);
      e1_r[k] <= EW'(crn_b[k]) - EW'(crn_a[k]);
      e2_r[k] <= EW'(pnt[k]) - EW'(crn_a[k]);
    end
  end

  // Stage 2: component products
  logic                 s2_vld_r;
  logic signed [PW-1:0] p00_r [3];
  logic signed [PW-1:0] p01_r [3];
  logic signed [PW-1:0] p02_r [3];
  logic signed [PW-1:0] p11_r [3];
  logic signed [PW-1:0] p12_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    for (int k = 0; k < 3; k++) begin
      p00_r[k] <= e0_r[k] * e0_r[k];
      p01_r[k] <= e0_r[k] * e1_r[k];
      p02_r[k] <= e0_r[k] * e2_r[k];
      p11_r[k] <= e1_r[k] * e1_r[k];
      p12_r[k] <= e1_r[k] * e2_r[k];
    end
  end

  // Stage 3: dot products
  logic                 s3_vld_r;
  logic signed [DW-1:0] d00_r, d01_r, d02_r, d11_r, d12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    d00_r <= DW'(p00_r[0]) + DW'(p00_r[1]) + DW'(p00_r[2]);
    d01_r <= DW'(p01_r[0]) + DW'(p01_r[1]) + DW'(p01_r[2]);
    d02_r <= DW'(p02_r[0]) + DW'(p02_r[1]) + DW'(p02_r[2]);
    d11_r <= DW'(p11_r[0]) + DW'(p11_r[1]) + DW'(p11_r[2]);
    d12_r <= DW'(p12_r[0]) + DW'(p12_r[1]) + DW'(p12_r[2]);
  end

  // Operand pairs of the six wide products
  logic signed [DW-1:0] mul_a [6];
  logic signed [DW-1:0] mul_b [6];

  always_comb begin
    mul_a[0] = d00_r; mul_b[0] = d11_r;
    mul_a[1] = d01_r; mul_b[1] = d01_r;
    mul_a[2] = d11_r; mul_b[2] = d02_r;
    mul_a[3] = d01_r; mul_b[3] = d12_r;
    mul_a[4] = d00_r; mul_b[4] = d12_r;
    mul_a[5] = d01_r; mul_b[5] = d02_r;
  end

  // Stage 4: partial products against the low and high slices
  logic                      s4_vld_r;
  logic signed [DW+LB:0]     plo_r [6];
  logic signed [DW+HB-1:0]   phi_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    for (int j = 0; j < 6; j++) begin
      plo_r[j] <= mul_a[j] * $signed({1'b0, mul_b[j][LB-1:0]});
      phi_r[j] <= mul_a[j] * $signed(mul_b[j][DW-1:LB]);
    end
  end

  // Stage 5: join the partial products
  logic                 s5_vld_r;
  logic signed [MW-1:0] prd_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    for (int j = 0; j < 6; j++) begin
      prd_r[j] <= (MW'(phi_r[j]) <<< LB) + MW'(plo_r[j]);
    end
  end

  // Stage 6: determinant and numerators
  logic                 s6_vld_r;
  logic signed [NW-1:0] den6_r, nu6_r, nv6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    den6_r <= NW'(prd_r[0]) - NW'(prd_r[1]);
    nu6_r  <= NW'(prd_r[2]) - NW'(prd_r[3]);
    nv6_r  <= NW'(prd_r[4]) - NW'(prd_r[5]);
  end

  // Stage 7: signs, magnitudes, inside decision on exact numerators
  logic              s7_vld_r;
  logic [NW-1:0]     den7_r, magu7_r, magv7_r;
  logic              negu7_r, negv7_r, ins7_r, dgn7_r;
  logic signed [NW:0] nsum;
  logic              dgn_nxt;

  always_comb begin
    nsum    = (NW+1)'(nu6_r) + (NW+1)'(nv6_r);
    dgn_nxt = (den6_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
    den7_r  <= den6_r;
    negu7_r <= nu6_r[NW-1];
    negv7_r <= nv6_r[NW-1];
    magu7_r <= nu6_r[NW-1] ? -nu6_r : nu6_r;
    magv7_r <= nv6_r[NW-1] ? -nv6_r : nv6_r;
    dgn7_r  <= dgn_nxt;
    ins7_r  <= !nu6_r[NW-1] && !nv6_r[NW-1] && (nsum <= (NW+1)'(den6_r)) && !dgn_nxt;
  end

  // Divider lanes: index 0 is stage 8, index k+1 follows divider step k
  logic          dv_vld_r [QB+1];
  logic [RW-1:0] rem_u_r  [QB+1];
  logic [RW-1:0] rem_v_r  [QB+1];
  logic [QB-1:0] quo_u_r  [QB+1];
  logic [QB-1:0] quo_v_r  [QB+1];
  logic [NW-1:0] dden_r   [QB+1];
  logic          neg_u_r  [QB+1];
  logic          neg_v_r  [QB+1];
  logic          sat_u_r  [QB+1];
  logic          sat_v_r  [QB+1];
  logic          ins_r    [QB+1];
  logic          dgn_r    [QB+1];

  // Stage 8: scaled numerators and saturation check against den * 2^QB
  logic [RW-1:0] remu_nxt, remv_nxt, dtop;

  always_comb begin
    remu_nxt = RW'(magu7_r) << WEIGHT_FRAC_BITS;
    remv_nxt = RW'(magv7_r) << WEIGHT_FRAC_BITS;
    dtop     = RW'(den7_r) << QB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= s7_vld_r;
    end
    rem_u_r[0] <= remu_nxt;
    rem_v_r[0] <= remv_nxt;
    quo_u_r[0] <= '0;
    quo_v_r[0] <= '0;
    dden_r[0]  <= den7_r;
    neg_u_r[0] <= negu7_r;
    neg_v_r[0] <= negv7_r;
    sat_u_r[0] <= (remu_nxt >= dtop);
    sat_v_r[0] <= (remv_nxt >= dtop);
    ins_r[0]   <= ins7_r;
    dgn_r[0]   <= dgn7_r;
  end

  // Restoring divider, one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] dsh;
    logic          ge_u, ge_v;

    always_comb begin
      dsh  = RW'(dden_r[k]) << (QB - 1 - k);
      ge_u = (rem_u_r[k] >= dsh);
      ge_v = (rem_v_r[k] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
      rem_u_r[k+1] <= ge_u ? rem_u_r[k] - dsh : rem_u_r[k];
      rem_v_r[k+1] <= ge_v ? rem_v_r[k] - dsh : rem_v_r[k];
      quo_u_r[k+1] <= {quo_u_r[k][QB-2:0], ge_u};
      quo_v_r[k+1] <= {quo_v_r[k][QB-2:0], ge_v};
      dden_r[k+1]  <= dden_r[k];
      neg_u_r[k+1] <= neg_u_r[k];
      neg_v_r[k+1] <= neg_v_r[k];
      sat_u_r[k+1] <= sat_u_r[k];
      sat_v_r[k+1] <= sat_v_r[k];
      ins_r[k+1]   <= ins_r[k];
      dgn_r[k+1]   <= dgn_r[k];
    end
  end

  // Output stage: sign, saturation, degenerate override
  localparam logic [WEIGHT_BITS-1:0] WMAX = {1'b0, {QB{1'b1}}};
  localparam logic [WEIGHT_BITS-1:0] WMIN = {1'b1, {QB{1'b0}}};

  logic [WEIGHT_BITS-1:0] wu_nxt, wv_nxt;
  logic                   out_valid_r, out_inside_r, out_degen_r;
  logic [WEIGHT_BITS-1:0] out_wu_r, out_wv_r;

  always_comb begin
    if (dgn_r[QB]) begin
      wu_nxt = '0;
    end else if (sat_u_r[QB]) begin
      wu_nxt = neg_u_r[QB] ? WMIN : WMAX;
    end else begin
      wu_nxt = neg_u_r[QB] ? -{1'b0, quo_u_r[QB]} : {1'b0, quo_u_r[QB]};
    end
    if (dgn_r[QB]) begin
      wv_nxt = '0;
    end else if (sat_v_r[QB]) begin
      wv_nxt = neg_v_r[QB] ? WMIN : WMAX;
    end else begin
      wv_nxt = neg_v_r[QB] ? -{1'b0, quo_v_r[QB]} : {1'b0, quo_v_r[QB]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld_r[QB];
    end
    out_wu_r     <= wu_nxt;
    out_wv_r     <= wv_nxt;
    out_inside_r <= ins_r[QB];
    out_degen_r  <= dgn_r[QB];
  end

  assign out_valid      = out_valid_r;
  assign out_weight_u   = out_wu_r;
  assign out_weight_v   = out_wv_r;
  assign out_inside_res = out_inside_r;
  assign out_degenerate = out_degen_r;

`ifndef ASSERT_OFF
  // Every accepted beat yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after pipeline latency");

  // A degenerate triangle gives zero weights and is never inside
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_weight_u == '0 && out_weight_v == '0 && !out_inside_res))
    else $error("degenerate result with nonzero fields");

  // Inside implies both weights non-negative
  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_res) |-> (!out_weight_u[WEIGHT_BITS-1] &&
      !out_weight_v[WEIGHT_BITS-1]))
    else $error("inside flagged with a negative weight");
`endif

endmodule
